FILE: src/mm_pkg.sv
// shared constants, types and codes for the matrix multiplier
package mm_pkg;

    localparam int MAX_DIM   = 8;
    localparam int DIM_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W     = $clog2(MAX_DIM + 1);
    localparam int ADDR_W    = 2 * DIM_W;
    localparam int RAM_DEPTH = 1 << ADDR_W;
    localparam int DATA_W    = 32;
    localparam int TDATA_W   = 40;
    localparam int STATUS_W  = 2;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_MISMATCH = 2'd1,
        STATUS_SHAPE    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_LOAD,
        S_DECIDE,
        S_MAC,
        S_DRAIN,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic load_en;
        logic start_prod;
        logic mac_issue;
        logic load_result;
        logic next_elem;
        logic clear_run;
    } cmd_t;

    typedef struct packed {
        logic run_ok;
        logic k_last;
        logic pipe_busy;
        logic res_last;
    } sts_t;

endpackage

FILE: src/mm_ram.sv
// generic single write port ram with registered read
module mm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/mm_ctrl.sv
// controller state machine sequencing load, multiply-accumulate and result transactions
module mm_ctrl
    import mm_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic run_end,
    input  logic m_ready,
    input  sts_t sts,
    output cmd_t cmd,
    output logic s_ready,
    output logic m_valid
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD: begin
                if (s_valid && run_end) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                state_next = sts.run_ok ? S_MAC : S_EMIT;
            end
            S_MAC: begin
                if (sts.k_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!sts.pipe_busy) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (m_ready) begin
                    state_next = sts.res_last ? S_LOAD : S_MAC;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            S_LOAD: begin
                s_ready     = 1'b1;
                cmd.load_en = s_valid;
            end
            S_DECIDE: begin
                cmd.start_prod  = sts.run_ok;
                cmd.load_result = !sts.run_ok;
            end
            S_MAC: begin
                cmd.mac_issue = 1'b1;
            end
            S_DRAIN: begin
                cmd.load_result = !sts.pipe_busy;
            end
            S_EMIT: begin
                m_valid       = 1'b1;
                cmd.clear_run = m_ready && sts.res_last;
                cmd.next_elem = m_ready && !sts.res_last;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: src/mm_datapath.sv
// datapath: shape tracking, matrix stores, index counters, mac pipeline, result register
module mm_datapath
    import mm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    input  logic              in_which,
    input  logic [DATA_W-1:0] in_value,
    input  logic              in_row_end,
    input  logic              in_matrix_end,
    output sts_t              sts,
    output logic [DATA_W-1:0] res_value,
    output logic              res_row_last,
    output logic              res_run_last,
    output status_t           res_status
);

    logic [CNT_W-1:0] left_rows_reg, left_rows_next;
    logic [CNT_W-1:0] left_cols_reg, left_cols_next;
    logic [CNT_W-1:0] right_rows_reg, right_rows_next;
    logic [CNT_W-1:0] right_cols_reg, right_cols_next;
    logic [CNT_W-1:0] col_counter_reg, col_counter_next;
    logic             shape_error_reg, shape_error_next;
    logic             cur_matrix_reg, cur_matrix_next;
    logic             left_done_reg, left_done_next;

    logic [CNT_W-1:0] ld_cc;
    logic [CNT_W-1:0] ld_c;
    logic [CNT_W-1:0] ld_r;
    logic [CNT_W-1:0] ld_cols;
    logic             ld_rend;
    logic             wr_en;
    logic [ADDR_W-1:0] wr_addr;

    logic [DIM_W-1:0] i_reg, j_reg, k_reg;
    logic             v1_reg, v2_reg;
    logic [DATA_W-1:0] prod_reg;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] a_q, b_q;

    logic [DATA_W-1:0] res_value_reg;
    logic              res_row_last_reg;
    logic              res_run_last_reg;
    status_t           res_status_reg;

    status_t run_status;
    logic    j_last, i_last;

    // shape tracking for one loaded element
    always_comb begin
        left_rows_next   = left_rows_reg;
        left_cols_next   = left_cols_reg;
        right_rows_next  = right_rows_reg;
        right_cols_next  = right_cols_reg;
        col_counter_next = col_counter_reg;
        shape_error_next = shape_error_reg;
        cur_matrix_next  = cur_matrix_reg;
        left_done_next   = left_done_reg;
        ld_rend          = in_row_end || in_matrix_end;
        ld_cc            = col_counter_reg;
        ld_c             = col_counter_reg;
        ld_r             = in_which ? right_rows_reg : left_rows_reg;
        ld_cols          = in_which ? right_cols_reg : left_cols_reg;
        wr_en            = 1'b0;
        if (cmd.clear_run) begin
            left_rows_next   = '0;
            left_cols_next   = '0;
            right_rows_next  = '0;
            right_cols_next  = '0;
            col_counter_next = '0;
            shape_error_next = 1'b0;
            cur_matrix_next  = 1'b0;
            left_done_next   = 1'b0;
        end else if (cmd.load_en) begin
            if (!in_which && left_done_reg) begin
                shape_error_next = 1'b1;
            end else begin
                // matrix switch with a row open drops that row
                if ((in_which != cur_matrix_reg) && (ld_cc != '0)) begin
                    shape_error_next = 1'b1;
                    ld_cc            = '0;
                end
                cur_matrix_next = in_which;
                ld_c            = ld_cc;
                if ((ld_r >= CNT_W'(MAX_DIM)) || (ld_c >= CNT_W'(MAX_DIM))) begin
                    shape_error_next = 1'b1;
                end else begin
                    wr_en = 1'b1;
                    ld_cc = ld_c + CNT_W'(1);
                end
                if (ld_rend) begin
                    if (ld_r == '0) begin
                        ld_cols = ld_cc;
                    end else if (ld_cc != ld_cols) begin
                        shape_error_next = 1'b1;
                    end
                    if (ld_r < CNT_W'(MAX_DIM)) begin
                        ld_r = ld_r + CNT_W'(1);
                    end
                    ld_cc = '0;
                end
                col_counter_next = ld_cc;
                if (in_which) begin
                    right_rows_next = ld_r;
                    right_cols_next = ld_cols;
                end else begin
                    left_rows_next = ld_r;
                    left_cols_next = ld_cols;
                    if (in_matrix_end) begin
                        left_done_next = 1'b1;
                    end
                end
            end
        end
    end

    assign wr_addr = {ld_c[DIM_W-1:0], ld_c[DIM_W-1:0]} & '0
                   | {(in_which ? right_rows_reg[DIM_W-1:0] : left_rows_reg[DIM_W-1:0]),
                      ld_c[DIM_W-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_rows_reg   <= '0;
            left_cols_reg   <= '0;
            right_rows_reg  <= '0;
            right_cols_reg  <= '0;
            col_counter_reg <= '0;
            shape_error_reg <= 1'b0;
            cur_matrix_reg  <= 1'b0;
            left_done_reg   <= 1'b0;
        end else begin
            left_rows_reg   <= left_rows_next;
            left_cols_reg   <= left_cols_next;
            right_rows_reg  <= right_rows_next;
            right_cols_reg  <= right_cols_next;
            col_counter_reg <= col_counter_next;
            shape_error_reg <= shape_error_next;
            cur_matrix_reg  <= cur_matrix_next;
            left_done_reg   <= left_done_next;
        end
    end

    mm_ram #(
        .WIDTH(DATA_W),
        .DEPTH(RAM_DEPTH)
    ) u_left_ram (
        .aclk    (aclk),
        .wr_en   (wr_en && !in_which),
        .wr_addr (wr_addr),
        .wr_data (in_value),
        .rd_addr ({i_reg, k_reg}),
        .rd_data (a_q)
    );

    mm_ram #(
        .WIDTH(DATA_W),
        .DEPTH(RAM_DEPTH)
    ) u_right_ram (
        .aclk    (aclk),
        .wr_en   (wr_en && in_which),
        .wr_addr (wr_addr),
        .wr_data (in_value),
        .rd_addr ({k_reg, j_reg}),
        .rd_data (b_q)
    );

    // outcome of the run from the final shape
    always_comb begin
        if (shape_error_reg || !left_done_reg) begin
            run_status = STATUS_SHAPE;
        end else if (left_cols_reg != right_rows_reg) begin
            run_status = STATUS_MISMATCH;
        end else begin
            run_status = STATUS_OK;
        end
    end

    assign j_last = (CNT_W'(j_reg) + CNT_W'(1)) == right_cols_reg;
    assign i_last = (CNT_W'(i_reg) + CNT_W'(1)) == left_rows_reg;

    // index counters
    always_ff @(posedge aclk) begin
        if (cmd.start_prod) begin
            i_reg <= '0;
            j_reg <= '0;
            k_reg <= '0;
        end else if (cmd.next_elem) begin
            k_reg <= '0;
            if (j_last) begin
                j_reg <= '0;
                i_reg <= i_reg + DIM_W'(1);
            end else begin
                j_reg <= j_reg + DIM_W'(1);
            end
        end else if (cmd.mac_issue) begin
            k_reg <= k_reg + DIM_W'(1);
        end
    end

    // read, multiply, accumulate pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.mac_issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            prod_reg <= a_q * b_q;
        end
        if (cmd.start_prod || cmd.next_elem) begin
            acc_reg <= '0;
        end else if (v2_reg) begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            res_status_reg <= run_status;
            if (run_status == STATUS_OK) begin
                res_value_reg    <= acc_reg;
                res_row_last_reg <= j_last;
                res_run_last_reg <= j_last && i_last;
            end else begin
                res_value_reg    <= '0;
                res_row_last_reg <= 1'b0;
                res_run_last_reg <= 1'b1;
            end
        end
    end

    assign sts.run_ok    = (run_status == STATUS_OK);
    assign sts.k_last    = (CNT_W'(k_reg) + CNT_W'(1)) == left_cols_reg;
    assign sts.pipe_busy = v1_reg || v2_reg;
    assign sts.res_last  = res_run_last_reg;

    assign res_value    = res_value_reg;
    assign res_row_last = res_row_last_reg;
    assign res_run_last = res_run_last_reg;
    assign res_status   = res_status_reg;

endmodule

FILE: src/matrix_multiply.sv
// top level of the streaming integer matrix multiplier
//
// channel   direction  tdata                          tuser          tlast
// s_axis    in         [31:0] elem_value [32] row_end which_matrix   matrix_end
// m_axis    out        [31:0] prod_value [32] row_last status        run_last
//
// loading takes one cycle per element transaction
// after the transaction that ends the right matrix comes a decision state, then each
// product element is accumulated on the shared multiply-accumulate unit and drained
// a mismatch or shape status goes to the result register in the decision state
// no input is taken while results are computed or wait on m_axis_tready
// synchronous active-low reset, the stores need no clearing
module matrix_multiply
    import mm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,  // elem_value, row_end, zero pad
    input  logic               s_axis_tuser,  // which_matrix
    input  logic               s_axis_tlast,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,  // prod_value, row_last, zero pad
    output logic [STATUS_W-1:0] m_axis_tuser, // status
    output logic               m_axis_tlast
);

    cmd_t              cmd;
    sts_t              sts;
    logic [DATA_W-1:0] res_value;
    logic              res_row_last;
    logic              res_run_last;
    status_t           res_status;

    mm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .run_end (s_axis_tuser && s_axis_tlast),
        .m_ready (m_axis_tready),
        .sts     (sts),
        .cmd     (cmd),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid)
    );

    mm_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .in_which      (s_axis_tuser),
        .in_value      (s_axis_tdata[DATA_W-1:0]),
        .in_row_end    (s_axis_tdata[DATA_W]),
        .in_matrix_end (s_axis_tlast),
        .sts           (sts),
        .res_value     (res_value),
        .res_row_last  (res_row_last),
        .res_run_last  (res_run_last),
        .res_status    (res_status)
    );

    assign m_axis_tdata = {{(TDATA_W - DATA_W - 1){1'b0}}, res_row_last, res_value};
    assign m_axis_tuser = res_status;
    assign m_axis_tlast = res_run_last;

endmodule
